// ----- src/wbr_pkg.sv -----
package wbr_pkg;

   // A data block shorter than this ends the transfer
   localparam logic [15:0] FULL_BLOCK_BYTES = 16'd512;
   localparam logic [7:0]  DATA_OPCODE      = 8'd3;

   // Configuration register indexes
   localparam logic REG_WINDOW_SIZE   = 1'b0;
   localparam logic REG_TIMEOUT_TICKS = 1'b1;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_PACKET = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_REQ    = 3'd1,
      PH_RECV   = 3'd2,
      PH_LINGER = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  packet_opcode;
      logic [15:0] blk_num;
      logic [9:0]  payload_size;
   } item_type;

   typedef struct packed {
      logic        send_request;
      logic        send_ack;
      logic [15:0] ack_block;
      logic        deliver_block;
      logic [9:0]  deliver_size;
      logic        transfer_done;
      phase_type   phase_now;
   } result_type;

   typedef struct packed {
      logic [7:0]  window_size;
      logic [15:0] timeout_ticks;
   } cfg_type;

endpackage

// ----- src/wbr_core.sv -----
module wbr_core import wbr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [15:0] expected_ff, expected_in;
   logic [7:0]  window_ff, window_in;
   logic [15:0] last_acked_ff, last_acked_in;
   logic        acked_valid_ff, acked_valid_in;
   logic [15:0] idle_ff, idle_in;
   logic [15:0] since_ff, since_in;

   phase_type   rx_phase;
   logic        is_data, in_order, is_short, ooo_ack, silence_to;
   logic [15:0] idle_inc, idle_after, expected_inc;
   logic [7:0]  window_dec;

   // A packet while requesting is handled as if already receiving
   assign rx_phase     = (phase_ff == PH_REQ) ? PH_RECV : phase_ff;
   assign is_data      = (item.packet_opcode == DATA_OPCODE);
   assign in_order     = (item.blk_num == expected_ff);
   assign is_short     = ({6'd0, item.payload_size} < FULL_BLOCK_BYTES);
   assign expected_inc = expected_ff + 16'd1;
   assign window_dec   = (window_ff != 8'd0) ? window_ff - 8'd1 : 8'd0;
   assign ooo_ack      = !acked_valid_ff || (last_acked_ff != expected_ff) ||
                         (since_ff >= cfg.timeout_ticks);

   // Silence counter saturates, then wraps to zero on timeout
   assign idle_inc   = (idle_ff != 16'hFFFF) ? idle_ff + 16'd1 : idle_ff;
   assign silence_to = (idle_inc >= cfg.timeout_ticks);
   assign idle_after = silence_to ? 16'd0 : idle_inc;

   // Next state
   always_comb begin
      phase_in       = phase_ff;
      expected_in    = expected_ff;
      window_in      = window_ff;
      last_acked_in  = last_acked_ff;
      acked_valid_in = acked_valid_ff;
      idle_in        = idle_ff;
      since_in       = since_ff;
      case (item.cmd)
         CMD_START: begin
            phase_in       = PH_REQ;
            expected_in    = 16'd0;
            window_in      = cfg.window_size;
            last_acked_in  = 16'd0;
            acked_valid_in = 1'b0;
            idle_in        = 16'd0;
            since_in       = 16'd0;
         end
         CMD_PACKET: begin
            if (rx_phase == PH_RECV) begin
               phase_in = PH_RECV;
               idle_in  = 16'd0;
               if (is_data && in_order) begin
                  expected_in = expected_inc;
                  window_in   = window_dec;
                  if (is_short) begin
                     phase_in = PH_LINGER;
                  end else if (window_dec == 8'd0) begin
                     window_in = cfg.window_size;
                  end
               end else if (is_data && ooo_ack) begin
                  window_in      = cfg.window_size;
                  last_acked_in  = expected_ff;
                  acked_valid_in = 1'b1;
                  since_in       = 16'd0;
               end
            end else if (phase_ff == PH_LINGER) begin
               idle_in = 16'd0;
            end
         end
         CMD_TICK: begin
            if (since_ff < cfg.timeout_ticks) begin
               since_in = since_ff + 16'd1;
            end
            case (phase_ff)
               PH_REQ: begin
                  idle_in = idle_after;
               end
               PH_RECV: begin
                  idle_in = idle_after;
                  if (silence_to) begin
                     window_in = cfg.window_size;
                  end
               end
               PH_LINGER: begin
                  idle_in = idle_after;
                  if (silence_to) begin
                     phase_in = PH_DONE;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // Result
   always_comb begin
      result               = '0;
      result.phase_now     = phase_in;
      case (item.cmd)
         CMD_START: begin
            result.send_request = 1'b1;
         end
         CMD_PACKET: begin
            if (rx_phase == PH_RECV) begin
               if (is_data && in_order) begin
                  result.deliver_block = 1'b1;
                  result.deliver_size  = item.payload_size;
                  if (is_short || (window_dec == 8'd0)) begin
                     result.send_ack  = 1'b1;
                     result.ack_block = expected_inc;
                  end
               end else if (is_data && ooo_ack) begin
                  result.send_ack  = 1'b1;
                  result.ack_block = expected_ff;
               end
            end else if (phase_ff == PH_LINGER) begin
               result.send_ack  = 1'b1;
               result.ack_block = expected_ff;
            end
         end
         CMD_TICK: begin
            case (phase_ff)
               PH_REQ:    result.send_request  = silence_to;
               PH_RECV: begin
                  if (silence_to) begin
                     result.send_ack  = 1'b1;
                     result.ack_block = expected_ff;
                  end
               end
               PH_LINGER: result.transfer_done = silence_to;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         expected_ff    <= 16'd0;
         window_ff      <= 8'd0;
         last_acked_ff  <= 16'd0;
         acked_valid_ff <= 1'b0;
         idle_ff        <= 16'd0;
         since_ff       <= 16'd0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         expected_ff    <= expected_in;
         window_ff      <= window_in;
         last_acked_ff  <= last_acked_in;
         acked_valid_ff <= acked_valid_in;
         idle_ff        <= idle_in;
         since_ff       <= since_in;
      end
   end

endmodule

// ----- src/windowed_block_receiver_top.sv -----
// Receiver side of a windowed block transfer. Each item is one event (start,
// packet arrived, one tick) and yields exactly one result item saying whether
// to send the read request or an acknowledgement, whether to keep the payload,
// and the phase afterwards. One item is taken every cycle while the output
// does not stall: an item taken sits in the input register, the state update
// and result are formed in the logic behind it, and the result register loads
// them once it is empty or its result is taken. While a result waits with
// rsp_tready low, one more item can be taken into the input register; req_tready
// then stays low until the result is taken. Registers are to be written through
// the csr port only while no item is in flight; the block does not enforce it.
module windowed_block_receiver_top import wbr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd
   input  logic [39:0] req_tdata,   // packet_opcode, blk_num, payload_size, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // send_request, send_ack, ack_block, deliver_block, deliver_size,
   // transfer_done, phase_now, zero fill
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_waddr,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_valid_ff, out_valid_ff;
   item_type   item_ff;
   result_type result_ff, result;
   logic       advance, step_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_size   <= 8'd8;
         cfg_ff.timeout_ticks <= 16'd1000;
      end else if (csr_we) begin
         case (csr_waddr)
            REG_WINDOW_SIZE:   cfg_ff.window_size   <= csr_wdata[7:0];
            REG_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Result register moves when empty or taken; input register drains into it
   assign advance    = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.cmd           <= cmd_type'(req_tuser);
         item_ff.packet_opcode <= req_tdata[7:0];
         item_ff.blk_num       <= req_tdata[23:8];
         item_ff.payload_size  <= req_tdata[33:24];
      end
   end

   wbr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0,
                        result_ff.phase_now,
                        result_ff.transfer_done,
                        result_ff.deliver_size,
                        result_ff.deliver_block,
                        result_ff.ack_block,
                        result_ff.send_ack,
                        result_ff.send_request};

   a_ack_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result_ff.send_ack |->
         result_ff.phase_now == PH_RECV || result_ff.phase_now == PH_LINGER)
      else $error("acknowledgement outside receiving or lingering");

   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result_ff.transfer_done |-> result_ff.phase_now == PH_DONE)
      else $error("transfer done without done phase");

   a_req_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result_ff.send_request |->
         !result_ff.send_ack && !result_ff.deliver_block && !result_ff.transfer_done)
      else $error("request sent together with other action");

   a_size_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !result_ff.deliver_block |-> result_ff.deliver_size == 10'd0)
      else $error("size without delivery");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance |=> rsp_tvalid)
      else $error("processed item lost");

endmodule
